@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for the concurrent checks of the infrared transmitter.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is high.
`define NECTX_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("nectx check failed");

// Next-cycle implication, switched off while reset is high.
`define NECTX_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("nectx check failed");

// Next-cycle implication that also holds across reset.
`define NECTX_ASSERT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("nectx check failed");

`endif

@@ hdl/nectx_pkg.sv @@
// ----------------------------------------------------------------------------
// nectx_pkg
// Types and constants shared by the infrared transmitter modules.
// ----------------------------------------------------------------------------
package nectx_pkg;

  localparam int DEF_BUFFER_DEPTH = 1024;
  localparam int DEF_NEC_BITS     = 32;

  localparam int KIND_W   = 2;
  localparam int INDEX_W  = 10;
  localparam int VALUE_W  = 16;
  localparam int STATUS_W = 16;
  localparam int TICKS_W  = 16;
  localparam int SEG_W    = 11;
  localparam int CFG_W    = 3;

  // Input item kinds.
  localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_START = 2'd2;

  // Start modes in status bits 14..12.
  localparam logic [2:0] MODE_NEC = 3'd0;
  localparam logic [2:0] MODE_RAW = 3'd1;

  // Configuration register indexes.
  localparam logic [CFG_W-1:0] CFG_LEADER_MARK  = 3'd0;
  localparam logic [CFG_W-1:0] CFG_LEADER_SPACE = 3'd1;
  localparam logic [CFG_W-1:0] CFG_BIT_MARK     = 3'd2;
  localparam logic [CFG_W-1:0] CFG_ONE_SPACE    = 3'd3;
  localparam logic [CFG_W-1:0] CFG_ZERO_SPACE   = 3'd4;

  // Register reset values.
  localparam logic [TICKS_W-1:0] RST_LEADER_MARK  = 16'd9000;
  localparam logic [TICKS_W-1:0] RST_LEADER_SPACE = 16'd4500;
  localparam logic [TICKS_W-1:0] RST_BIT_MARK     = 16'd560;
  localparam logic [TICKS_W-1:0] RST_ONE_SPACE    = 16'd1680;
  localparam logic [TICKS_W-1:0] RST_ZERO_SPACE   = 16'd560;

  // One result word.
  typedef struct packed {
    logic line_level;
    logic busy_res;
  } result_t;

endpackage

@@ hdl/nectx_ram.sv @@
// ----------------------------------------------------------------------------
// nectx_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module nectx_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hdl/nec_ir_transmitter.sv @@
// ----------------------------------------------------------------------------
// nec_ir_transmitter
// Infrared transmit line driver: NEC frames or raw timing replay, one tick
// item per microsecond of line time.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                                   Direction
//  -------   ---------------------------------------   ---------
//  input     in_valid, in_stall, kind, entry_index,    in
//            entry_value, status_word
//  output    out_valid, out_stall, line_level,         out
//            busy_res
//  config    cfg_write, cfg_index, cfg_data            in
//
// Every accepted word is processed in the cycle it is accepted and its result
// is registered into the output buffer, so the block takes one word per clock
// while in_stall is low. Raw durations come from the entry RAM; the entry for
// the next segment is prefetched when a segment begins, so the registered read
// is ready when that segment ends. Reset is synchronous; the entry buffer is
// not cleared and needs no clearing pass.
// A two-word output buffer lets input continue while a result waits; in_stall
// rises only when both slots are full.
//
module nec_ir_transmitter #(
  parameter int BUFFER_DEPTH = nectx_pkg::DEF_BUFFER_DEPTH,
  parameter int NEC_BITS     = nectx_pkg::DEF_NEC_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [nectx_pkg::KIND_W-1:0]    kind,
  input  logic [nectx_pkg::INDEX_W-1:0]   entry_index,
  input  logic [nectx_pkg::VALUE_W-1:0]   entry_value,
  input  logic [nectx_pkg::STATUS_W-1:0]  status_word,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            line_level,
  output logic                            busy_res,
  input  logic                            cfg_write,
  input  logic [nectx_pkg::CFG_W-1:0]     cfg_index,
  input  logic [nectx_pkg::TICKS_W-1:0]   cfg_data
);

  import nectx_pkg::*;

  // Address arithmetic is done at 13 bits, enough for any depth up to 4096
  // plus the prefetch offset.
  localparam int AW = $clog2(BUFFER_DEPTH);
  localparam int IW = 13;
  localparam logic [IW-1:0]    DEPTH_LIM = IW'(BUFFER_DEPTH);
  localparam logic [SEG_W-1:0] LAST_SEG  = SEG_W'(2 + 2 * NEC_BITS);
  localparam int               NEC_SHIFT = 32 - NEC_BITS;

  // Timing registers.
  logic [TICKS_W-1:0] leader_mark_ticks;
  logic [TICKS_W-1:0] leader_space_ticks;
  logic [TICKS_W-1:0] bit_mark_ticks;
  logic [TICKS_W-1:0] one_space_ticks;
  logic [TICKS_W-1:0] zero_space_ticks;

  always_ff @(posedge clk) begin
    if (rst) begin
      leader_mark_ticks  <= RST_LEADER_MARK;
      leader_space_ticks <= RST_LEADER_SPACE;
      bit_mark_ticks     <= RST_BIT_MARK;
      one_space_ticks    <= RST_ONE_SPACE;
      zero_space_ticks   <= RST_ZERO_SPACE;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_LEADER_MARK:  leader_mark_ticks  <= cfg_data;
        CFG_LEADER_SPACE: leader_space_ticks <= cfg_data;
        CFG_BIT_MARK:     bit_mark_ticks     <= cfg_data;
        CFG_ONE_SPACE:    one_space_ticks    <= cfg_data;
        CFG_ZERO_SPACE:   zero_space_ticks   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer state.
  logic [SEG_W-1:0]   segment_number, segment_number_next;
  logic [TICKS_W-1:0] ticks_left, ticks_left_next;
  logic [31:0]        data_shift, data_shift_next;
  logic               raw_mode, raw_mode_next;
  logic [INDEX_W-1:0] raw_count, raw_count_next;
  logic               active, active_next;
  logic               level_now, level_now_next;

  // Entries 0 and 1 are also kept in registers: the start of NEC mode needs both
  // and raw mode needs entry 0 in the same cycle, before the RAM could deliver them.
  logic [VALUE_W-1:0] entry0, entry1;

  // Entry RAM and its prefetch.
  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [VALUE_W-1:0] ram_rdata;
  logic [IW-1:0]      idx_ext, pf_addr;
  logic               idx_ok, pf_ok, rd_ok;

  logic               in_accept;
  result_t            res;

  logic [SEG_W-1:0]   seg_inc;
  logic [TICKS_W-1:0] tick_dec;
  logic [TICKS_W-1:0] dur;
  logic               seg_begin;
  logic [2:0]         mode;

  assign in_accept = in_valid && !in_stall;
  assign mode      = status_word[14:12];
  assign seg_inc   = segment_number + SEG_W'(1);
  assign tick_dec  = ticks_left - TICKS_W'(1);
  assign idx_ext   = IW'(entry_index);
  assign idx_ok    = idx_ext < DEPTH_LIM;
  assign ram_waddr = idx_ext[AW-1:0];

  always_comb begin
    segment_number_next = segment_number;
    ticks_left_next     = ticks_left;
    data_shift_next     = data_shift;
    raw_mode_next       = raw_mode;
    raw_count_next      = raw_count;
    active_next         = active;
    level_now_next      = level_now;
    dur                 = '0;
    seg_begin           = 1'b0;
    ram_we              = 1'b0;
    ram_re              = 1'b0;
    pf_addr             = IW'(seg_inc) + IW'(1);
    res.line_level      = level_now;
    res.busy_res        = active;

    if (in_accept) begin
      unique case (kind)
        KIND_TICK: begin
          if (active) begin
            ticks_left_next = tick_dec;
            if (tick_dec == '0) begin
              segment_number_next = seg_inc;
              seg_begin           = 1'b1;
              if (raw_mode) begin
                if (seg_inc >= SEG_W'(raw_count)) begin
                  seg_begin = 1'b0;
                end else begin
                  dur            = rd_ok ? ram_rdata : '0;
                  level_now_next = ~seg_inc[0];
                  ram_re         = 1'b1;
                end
              end else if (seg_inc == SEG_W'(1)) begin
                dur            = leader_space_ticks;
                level_now_next = 1'b1;
              end else if (seg_inc < LAST_SEG) begin
                if (!seg_inc[0]) begin
                  dur            = bit_mark_ticks;
                  level_now_next = 1'b0;
                end else begin
                  dur             = data_shift[31] ? one_space_ticks : zero_space_ticks;
                  data_shift_next = {data_shift[30:0], 1'b0};
                  level_now_next  = 1'b1;
                end
              end else if (seg_inc == LAST_SEG) begin
                dur            = bit_mark_ticks;
                level_now_next = 1'b0;
              end else begin
                seg_begin = 1'b0;
              end
              if (!seg_begin) begin
                active_next     = 1'b0;
                level_now_next  = 1'b1;
                ticks_left_next = '0;
              end
            end
          end
        end
        KIND_WRITE: begin
          if (!active) begin
            ram_we = idx_ok;
          end
        end
        KIND_START: begin
          if (!active) begin
            if (mode == MODE_RAW) begin
              raw_count_next = status_word[INDEX_W-1:0];
              if (status_word[INDEX_W-1:0] != '0) begin
                raw_mode_next       = 1'b1;
                segment_number_next = '0;
                seg_begin           = 1'b1;
                dur                 = entry0;
                level_now_next      = 1'b1;
                active_next         = 1'b1;
                ram_re              = 1'b1;
                pf_addr             = IW'(1);
              end
            end else if (mode == MODE_NEC) begin
              raw_mode_next       = 1'b0;
              data_shift_next     = {entry1, entry0} << NEC_SHIFT;
              segment_number_next = '0;
              seg_begin           = 1'b1;
              dur                 = leader_mark_ticks;
              level_now_next      = 1'b0;
              active_next         = 1'b1;
            end
          end
        end
        default: ;
      endcase

      if (seg_begin) begin
        ticks_left_next = (dur == '0) ? TICKS_W'(1) : dur;
      end

      // A tick reports the level it was driven at; other kinds report the
      // state they leave behind.
      if (kind != KIND_TICK) begin
        res.line_level = level_now_next;
        res.busy_res   = active_next;
      end
    end
  end

  assign pf_ok     = pf_addr < DEPTH_LIM;
  assign ram_raddr = pf_addr[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      segment_number <= '0;
      ticks_left     <= '0;
      data_shift     <= '0;
      raw_mode       <= 1'b0;
      raw_count      <= '0;
      active         <= 1'b0;
      level_now      <= 1'b1;
      rd_ok          <= 1'b0;
    end else begin
      segment_number <= segment_number_next;
      ticks_left     <= ticks_left_next;
      data_shift     <= data_shift_next;
      raw_mode       <= raw_mode_next;
      raw_count      <= raw_count_next;
      active         <= active_next;
      level_now      <= level_now_next;
      if (ram_re) begin
        rd_ok <= pf_ok;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ram_we && (entry_index == INDEX_W'(0))) begin
      entry0 <= entry_value;
    end
    if (ram_we && (entry_index == INDEX_W'(1))) begin
      entry1 <= entry_value;
    end
  end

  nectx_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (BUFFER_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (entry_value),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // Two-word output buffer: slot0 drives the port, slot1 catches a word that
  // arrives while slot0 is held.
  result_t    slot0, slot1;
  logic [1:0] fill;
  logic       out_pop;

  assign out_pop   = out_valid && !out_stall;
  assign out_valid = fill != 2'd0;
  assign in_stall  = fill == 2'd2;
  assign line_level = slot0.line_level;
  assign busy_res   = slot0.busy_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= 2'd0;
    end else begin
      case ({in_accept, out_pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (fill == 2'd2) begin
      if (out_pop) begin
        slot0 <= slot1;
      end
    end else if (in_accept) begin
      if ((fill == 2'd0) || out_pop) begin
        slot0 <= res;
      end else begin
        slot1 <= res;
      end
    end
  end

endmodule

@@ hdl/nectx_checker.sv @@
// ----------------------------------------------------------------------------
// nectx_checker
// Port-level checks on the infrared transmitter, attached by bind.
// ----------------------------------------------------------------------------
module nectx_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic line_level,
  input logic busy_res
);

  `include "assert_macros.svh"

  // With no sequence playing, the line must sit at its idle level.
  `NECTX_ASSERT_NOW(a_idle_high, clk, rst, out_valid && !busy_res, line_level)

  // Reset empties the output buffer and opens the input.
  `NECTX_ASSERT_ALWAYS(a_reset_empty, clk, rst, !out_valid && !in_stall)

  // A held result word does not change.
  `NECTX_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall,
    out_valid && $stable(line_level) && $stable(busy_res))

  // The input is only stalled while a result is waiting.
  `NECTX_ASSERT_NOW(a_stall_needs_out, clk, rst, in_stall, out_valid)

endmodule

bind nec_ir_transmitter nectx_checker u_nectx_checker (.*);
